>>> rtl/gbm_pkg.sv
// Shared types, constants and helpers of the greedy box merge block.
package gbm_pkg;

    // Coordinate and extent widths follow the fixed payload fields
    localparam int COORD_BITS   = 12;
    localparam int EXT_BITS     = COORD_BITS + 1;
    localparam int MAX_BOXES_DF = 32;

    // Configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic REG_MERGE_DISTANCE = 1'b0;

    localparam logic [EXT_BITS-1:0] EXT_MAX = EXT_BITS'(1) << COORD_BITS;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WAIT,
        ST_DRAIN
    } t_gbm_state;

    typedef struct packed {
        logic [COORD_BITS-1:0] box_left;
        logic [COORD_BITS-1:0] box_top;
        logic [EXT_BITS-1:0]   box_width;
        logic [EXT_BITS-1:0]   box_height;
        logic                  final_box;
    } t_gbm_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_left;
        logic [COORD_BITS-1:0] out_top;
        logic [EXT_BITS-1:0]   out_width;
        logic [EXT_BITS-1:0]   out_height;
        logic                  out_last;
        logic                  dropped_any;
    } t_gbm_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] l;
        logic [COORD_BITS-1:0] t;
        logic [EXT_BITS-1:0]   w;
        logic [EXT_BITS-1:0]   h;
    } t_gbm_box;

    // One stored table entry
    typedef struct packed {
        logic     valid;
        t_gbm_box box;
    } t_gbm_entry;

    // Request moving down the chain; live until some cell absorbs it
    typedef struct packed {
        logic     valid;
        logic     live;
        logic     final_box;
        t_gbm_box box;
    } t_gbm_tok;

    // Clamp an extent to the largest legal size
    function automatic logic [EXT_BITS-1:0] gbm_sat(input logic [EXT_BITS-1:0] v);
        return (v > EXT_MAX) ? EXT_MAX : v;
    endfunction

endpackage

>>> rtl/gbm_cell.sv
// One table cell: holds a stored box, merges or absorbs a passing request.
module gbm_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [gbm_pkg::EXT_BITS-1:0] i_merge_distance,
    input  gbm_pkg::t_gbm_tok     i_tok,
    output gbm_pkg::t_gbm_tok     o_tok,
    input  logic                  i_shift,
    input  gbm_pkg::t_gbm_entry   i_neighbor,
    output gbm_pkg::t_gbm_entry   o_entry
);
    import gbm_pkg::*;

    t_gbm_entry r_entry, n_entry;
    t_gbm_tok   r_tok, n_tok;

    logic [COORD_BITS-1:0] dx, dy, lx, ty, ul, ut;
    logic [EXT_BITS-1:0]   e_r, e_b, b_r, b_b, rx, by, ur, ub;
    logic                  near, overlap, match, e_empty, b_empty;
    t_gbm_box              e, b, uni;

    assign e = r_entry.box;
    assign b = i_tok.box;

    // Match test: near corners or positive-area overlap
    always_comb begin
        dx   = (e.l > b.l) ? e.l - b.l : b.l - e.l;
        dy   = (e.t > b.t) ? e.t - b.t : b.t - e.t;
        near = ({1'b0, dx} < i_merge_distance) && ({1'b0, dy} < i_merge_distance);
        e_r  = {1'b0, e.l} + e.w;
        e_b  = {1'b0, e.t} + e.h;
        b_r  = {1'b0, b.l} + b.w;
        b_b  = {1'b0, b.t} + b.h;
        lx   = (e.l > b.l) ? e.l : b.l;
        ty   = (e.t > b.t) ? e.t : b.t;
        rx   = (e_r < b_r) ? e_r : b_r;
        by   = (e_b < b_b) ? e_b : b_b;
        overlap = (rx > {1'b0, lx}) && (by > {1'b0, ty});
        match   = near || overlap;
    end

    // Union of stored box and request, empty boxes handled apart
    always_comb begin
        e_empty = (e.w == '0) || (e.h == '0);
        b_empty = (b.w == '0) || (b.h == '0);
        ul = (e.l < b.l) ? e.l : b.l;
        ut = (e.t < b.t) ? e.t : b.t;
        ur = (e_r > b_r) ? e_r : b_r;
        ub = (e_b > b_b) ? e_b : b_b;
        if (e_empty) begin
            uni = b;
        end else if (b_empty) begin
            uni = e;
        end else begin
            uni.l = ul;
            uni.t = ut;
            uni.w = gbm_sat(ur - {1'b0, ul});
            uni.h = gbm_sat(ub - {1'b0, ut});
        end
    end

    // Shift toward the output on drain, otherwise serve the request
    always_comb begin
        n_entry = r_entry;
        n_tok   = i_tok;
        if (i_shift) begin
            n_entry = i_neighbor;
        end else if (i_tok.valid && i_tok.live) begin
            if (!r_entry.valid) begin
                n_entry.valid = 1'b1;
                n_entry.box   = b;
                n_tok.live    = 1'b0;
            end else if (match) begin
                n_entry.box = uni;
                n_tok.live  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_tok.valid   <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
            r_tok.valid   <= n_tok.valid;
        end
        r_entry.box     <= n_entry.box;
        r_tok.live      <= n_tok.live;
        r_tok.final_box <= n_tok.final_box;
        r_tok.box       <= n_tok.box;
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

>>> rtl/greedy_box_merge.sv
// Greedy bounding-box merge: top level with chain of table cells and control.
//
// Boxes enter a row of MAX_BOXES cells and walk down it one cell per cycle;
// the first stored box that matches absorbs the request, and the first empty
// cell stores an unmatched one, so a box that reaches the end of the row is
// dropped and flags overflow. Ordinary boxes are taken one per cycle. After a
// box marked final is taken, input stalls while it walks the row, then the
// stored boxes shift out of cell 0 one per accepted result, with out_last on
// the final one, and the set closes once cell 0 is empty; an empty table
// gives no results. The table is empty after reset with no clearing pass.
// merge_distance is written over the APB port at byte address 0; the user
// must write it only while the block is idle; the block does not enforce it.
module greedy_box_merge #(
    parameter int MAX_BOXES = gbm_pkg::MAX_BOXES_DF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  gbm_pkg::t_gbm_in                   i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output gbm_pkg::t_gbm_out                  o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gbm_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [gbm_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [gbm_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import gbm_pkg::*;

    t_gbm_state r_state, n_state;
    logic [EXT_BITS-1:0] r_merge_distance;
    logic     r_ovf;
    t_gbm_tok r_in_tok, n_in_tok;

    t_gbm_tok   tok [0:MAX_BOXES];
    t_gbm_entry ent [0:MAX_BOXES];

    logic in_accept, drain, shift, done;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_distance <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MERGE_DISTANCE)) begin
            r_merge_distance <= pwdata[EXT_BITS-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_MERGE_DISTANCE) ?
                    {{(CFG_DATA_BITS-EXT_BITS){1'b0}}, r_merge_distance} : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:  if (in_accept && i_in_data.final_box) n_state = ST_WAIT;
            ST_WAIT:  if (tok[MAX_BOXES].valid && tok[MAX_BOXES].final_box) n_state = ST_DRAIN;
            ST_DRAIN: if (done) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    // Control outputs
    always_comb begin
        o_in_stall  = (r_state != ST_LOAD);
        drain       = (r_state == ST_DRAIN);
        o_out_valid = drain && ent[0].valid;
        shift       = o_out_valid && !i_out_stall;
        done        = drain && !ent[0].valid;
        in_accept   = i_in_valid && !o_in_stall;
    end

    // Register the accepted request, clamping extents
    always_comb begin
        n_in_tok.valid     = in_accept;
        n_in_tok.live      = 1'b1;
        n_in_tok.final_box = i_in_data.final_box;
        n_in_tok.box.l     = i_in_data.box_left;
        n_in_tok.box.t     = i_in_data.box_top;
        n_in_tok.box.w     = gbm_sat(i_in_data.box_width);
        n_in_tok.box.h     = gbm_sat(i_in_data.box_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_LOAD;
            r_in_tok.valid <= 1'b0;
            r_ovf          <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_in_tok.valid <= n_in_tok.valid;
            // Flag a request that fell off the end; clear when the set closes
            if (tok[MAX_BOXES].valid && tok[MAX_BOXES].live) begin
                r_ovf <= 1'b1;
            end else if (done) begin
                r_ovf <= 1'b0;
            end
        end
        r_in_tok.live      <= n_in_tok.live;
        r_in_tok.final_box <= n_in_tok.final_box;
        r_in_tok.box       <= n_in_tok.box;
    end

    // Chain of cells
    assign tok[0]         = r_in_tok;
    assign ent[MAX_BOXES] = '0;

    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
        gbm_cell u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_merge_distance (r_merge_distance),
            .i_tok            (tok[g]),
            .o_tok            (tok[g+1]),
            .i_shift          (shift),
            .i_neighbor       (ent[g+1]),
            .o_entry          (ent[g])
        );
    end

    // Result comes straight from the head cell
    always_comb begin
        o_out_data.out_left    = ent[0].box.l;
        o_out_data.out_top     = ent[0].box.t;
        o_out_data.out_width   = ent[0].box.w;
        o_out_data.out_height  = ent[0].box.h;
        o_out_data.out_last    = !ent[1].valid;
        o_out_data.dropped_any = r_ovf;
    end

endmodule

>>> sim/greedy_box_merge_tb.sv
// Self-checking testbench for the greedy box merge block: directed and random box sets.
module greedy_box_merge_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbm_pkg::*;

    localparam int MAX_BOXES     = MAX_BOXES_DF;
    localparam int SETTLE_CYCLES = MAX_BOXES + 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 120;
    localparam logic [CFG_ADDR_BITS-1:0] MERGE_DISTANCE_ADDR =
        CFG_ADDR_BITS'(4 * int'(REG_MERGE_DISTANCE));

    // Track the merged-box table and hold the boxes each final request will emit
    class merged_box_board;
        t_gbm_box            slots[MAX_BOXES];
        int unsigned         filled;
        bit                  spilled;
        logic [EXT_BITS-1:0] distance;
        t_gbm_out            boxes_due[$];

        function new();
            filled   = 0;
            spilled  = 1'b0;
            distance = '0;
        endfunction

        function void set_distance(input logic [EXT_BITS-1:0] value);
            distance = value;
        endfunction

        function int unsigned gap(input int unsigned a, input int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function logic [EXT_BITS-1:0] clamp(input int unsigned v);
            return (v > EXT_MAX) ? EXT_MAX : EXT_BITS'(v);
        endfunction

        function bit is_empty(input t_gbm_box b);
            return (b.w == 0) || (b.h == 0);
        endfunction

        // Corners within the merge distance, or overlap with positive area
        function bit joins(input t_gbm_box e, input t_gbm_box b);
            int unsigned el, et, er, eb, bl, bt, br, bb, lx, rx, ty, by_;
            bit near;
            el = e.l; et = e.t; er = el + e.w; eb = et + e.h;
            bl = b.l; bt = b.t; br = bl + b.w; bb = bt + b.h;
            near = (gap(el, bl) < distance) && (gap(et, bt) < distance);
            lx  = (el > bl) ? el : bl;
            rx  = (er < br) ? er : br;
            ty  = (et > bt) ? et : bt;
            by_ = (eb < bb) ? eb : bb;
            return near || ((rx > lx) && (by_ > ty));
        endfunction

        // Union; an empty stored box takes the new one, an empty new box changes nothing
        function t_gbm_box merged(input t_gbm_box e, input t_gbm_box b);
            int unsigned l, t, r, bot;
            t_gbm_box u;
            if (is_empty(e)) return b;
            if (is_empty(b)) return e;
            l   = (e.l < b.l) ? e.l : b.l;
            t   = (e.t < b.t) ? e.t : b.t;
            r   = ((int'(e.l) + e.w) > (int'(b.l) + b.w)) ? int'(e.l) + e.w : int'(b.l) + b.w;
            bot = ((int'(e.t) + e.h) > (int'(b.t) + b.h)) ? int'(e.t) + e.h : int'(b.t) + b.h;
            u.l = COORD_BITS'(l);
            u.t = COORD_BITS'(t);
            u.w = clamp(r - l);
            u.h = clamp(bot - t);
            return u;
        endfunction

        // Apply one accepted request; on a final one, queue every stored box
        function void take_box(input t_gbm_in item);
            t_gbm_box b;
            t_gbm_out res;
            bit absorbed;
            b.l = item.box_left;
            b.t = item.box_top;
            b.w = clamp(item.box_width);
            b.h = clamp(item.box_height);
            absorbed = 1'b0;
            for (int i = 0; i < filled; i++) begin
                if (!absorbed && joins(slots[i], b)) begin
                    slots[i] = merged(slots[i], b);
                    absorbed = 1'b1;
                end
            end
            if (!absorbed) begin
                if (filled < MAX_BOXES) begin
                    slots[filled] = b;
                    filled++;
                end else begin
                    spilled = 1'b1;
                end
            end
            if (item.final_box) begin
                for (int i = 0; i < filled; i++) begin
                    res.out_left    = slots[i].l;
                    res.out_top     = slots[i].t;
                    res.out_width   = slots[i].w;
                    res.out_height  = slots[i].h;
                    res.out_last    = (i == filled - 1);
                    res.dropped_any = spilled;
                    boxes_due = {boxes_due, res};
                end
                filled  = 0;
                spilled = 1'b0;
            end
        endfunction

        // Compare a result with the oldest queued box; empty string when it matches
        function string check_box(input t_gbm_out got);
            t_gbm_out want;
            string diff;
            if (boxes_due.size() == 0)
                return $sformatf("unexpected box left %0d top %0d width %0d height %0d",
                                 got.out_left, got.out_top, got.out_width, got.out_height);
            want = boxes_due.pop_front();
            diff = "";
            if (got.out_left !== want.out_left)
                diff = {diff, $sformatf(" left %0d/%0d", got.out_left, want.out_left)};
            if (got.out_top !== want.out_top)
                diff = {diff, $sformatf(" top %0d/%0d", got.out_top, want.out_top)};
            if (got.out_width !== want.out_width)
                diff = {diff, $sformatf(" width %0d/%0d", got.out_width, want.out_width)};
            if (got.out_height !== want.out_height)
                diff = {diff, $sformatf(" height %0d/%0d", got.out_height, want.out_height)};
            if (got.out_last !== want.out_last)
                diff = {diff, $sformatf(" last %0b/%0b", got.out_last, want.out_last)};
            if (got.dropped_any !== want.dropped_any)
                diff = {diff, $sformatf(" dropped %0b/%0b", got.dropped_any, want.dropped_any)};
            if (diff != "") return {"box mismatch (got/expected):", diff};
            return "";
        endfunction
    endclass

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    t_gbm_in                  i_in_data   = '0;
    logic                     i_out_stall = 1'b0;
    logic                     psel        = 1'b0;
    logic                     penable     = 1'b0;
    logic                     pwrite      = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr       = '0;
    logic [CFG_DATA_BITS-1:0] pwdata      = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    t_gbm_out                 o_out_data;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    merged_box_board board;
    int errors        = 0;
    int items_sent    = 0;
    int send_idle_pct = 11;
    int recv_idle_pct = 77;
    int cur_distance  = 0;

    greedy_box_merge #(
        .MAX_BOXES(MAX_BOXES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        errors++;
        $display("[%0t] %s", $realtime, msg);
    endtask

    // Check accepted results, then draw the next stall
    always @(posedge i_clk) begin : result_monitor
        string msg;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            msg = board.check_box(o_out_data);
            if (msg != "") report(msg);
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offer one box request, idling first at the sender's rate, and wait for acceptance
    task automatic send_box(input int l, input int t, input int w, input int h, input bit fin);
        t_gbm_in item;
        item.box_left   = COORD_BITS'(l);
        item.box_top    = COORD_BITS'(t);
        item.box_width  = EXT_BITS'(w);
        item.box_height = EXT_BITS'(h);
        item.final_box  = fin;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_box(item);
        items_sent++;
    endtask

    // Drop valid, wait out every queued box, then let the row settle
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (board.boxes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer; the caller drops psel afterwards
    task automatic cfg_access(input logic wr, input logic [CFG_DATA_BITS-1:0] wdata,
                              output logic [CFG_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MERGE_DISTANCE_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
    endtask

    // Write merge_distance, read it back, and mirror it in the board
    task automatic set_merge_distance(input int value);
        logic [CFG_DATA_BITS-1:0] readback;
        cfg_access(1'b1, CFG_DATA_BITS'(value), readback);
        cfg_access(1'b0, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== CFG_DATA_BITS'(value))
            report($sformatf("merge_distance read %0h, wrote %0h", readback, value));
        board.set_distance(EXT_BITS'(value));
        cur_distance = value;
    endtask

    // One random set: clustered boxes, full-range boxes, or enough empty boxes to fill the table and often spill
    task automatic run_random_set();
        int kind, n, nc, k, l, t, w, h, base_l, base_t, d;
        int cx[4];
        int cy[4];
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            if (cur_distance > 1 || $urandom_range(0, 1) == 0) begin
                quiesce();
                set_merge_distance($urandom_range(0, 1));
            end
        end else if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
                0: d = 0;
                1: d = EXT_MAX;
                2: d = EXT_MAX - 1;
                3: d = $urandom_range(1, 64);
                default: d = $urandom_range(0, EXT_MAX);
            endcase
            quiesce();
            set_merge_distance(d);
        end

        nc = $urandom_range(1, 4);
        for (int j = 0; j < nc; j++) begin
            cx[j] = $urandom_range(0, 4095);
            cy[j] = $urandom_range(0, 4095);
        end
        base_l = $urandom_range(0, 4095);
        base_t = $urandom_range(0, 4095);
        if (kind < 2)      n = $urandom_range(MAX_BOXES - 1, MAX_BOXES + 6);
        else if (kind < 6) n = $urandom_range(1, 14);
        else               n = $urandom_range(1, 10);

        for (int i = 0; i < n; i++) begin
            if (kind < 2) begin
                // Distinct corners and empty boxes: nothing merges, so the table fills or nearly fills
                l = (base_l + i * 131) % 4096;
                t = (base_t + i * 257) % 4096;
                if ($urandom_range(0, 1) == 0) begin
                    w = 0;
                    h = $urandom_range(0, 8191);
                end else begin
                    w = $urandom_range(0, 8191);
                    h = 0;
                end
            end else if (kind < 6) begin
                k = $urandom_range(0, nc - 1);
                l = (cx[k] + $urandom_range(0, 40)) % 4096;
                t = (cy[k] + $urandom_range(0, 40)) % 4096;
                w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 48);
                h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 48);
            end else begin
                l = $urandom_range(0, 4095);
                t = $urandom_range(0, 4095);
                w = ($urandom_range(0, 3) == 0) ? EXT_MAX : $urandom_range(0, 8191);
                h = ($urandom_range(0, 3) == 0) ? EXT_MAX : $urandom_range(0, 8191);
            end
            send_box(l, t, w, h, i == n - 1);
        end
    endtask

    initial begin : stimulus
        int phase_start;
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_merge_distance(0);

        // Overlap only: saturated extents, corner overlap, empty box never overlapping
        send_box(0, 0, 8191, 8191, 1'b0);
        send_box(4095, 4095, 1, 1, 1'b0);
        send_box(100, 100, 0, 50, 1'b1);
        // Union wider than the frame saturates; empty boxes stay apart
        send_box(4095, 0, 4096, 5, 1'b0);
        send_box(4095, 2, 1, 1, 1'b0);
        send_box(10, 10, 0, 0, 1'b0);
        send_box(10, 10, 3, 3, 1'b1);
        quiesce();
        set_merge_distance(16);

        // Distance merges: empty stored box takes the new one, empty new box is absorbed,
        // a gap equal to the distance does not merge
        send_box(200, 200, 0, 0, 1'b0);
        send_box(210, 205, 5, 5, 1'b0);
        send_box(226, 200, 4, 4, 1'b0);
        send_box(215, 220, 0, 7, 1'b0);
        send_box(0, 4095, 4096, 1, 1'b1);
        quiesce();
        set_merge_distance(EXT_MAX);

        // Largest distance: everything in a set merges into its first box
        send_box(0, 0, 1, 1, 1'b0);
        send_box(4095, 4095, 8191, 0, 1'b0);
        send_box(4095, 0, 2, 2, 1'b1);
        send_box(4095, 4095, 4096, 4096, 1'b1);

        // Random sets under three idling mixes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 11; recv_idle_pct = 77; end
                1: begin send_idle_pct = 77; recv_idle_pct = 11; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) run_random_set();
        end

        quiesce();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/gbm_pkg.sv
rtl/gbm_cell.sv
rtl/greedy_box_merge.sv
sim/greedy_box_merge_tb.sv
